FILE: design/varint_zigzag_field_encoder_core_defines.svh
// Assertion macros shared by the varint field encoder RTL
`ifndef VARINT_ZIGZAG_FIELD_ENCODER_CORE_DEFINES_SVH
`define VARINT_ZIGZAG_FIELD_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define VZFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vzfe assertion failed");

// Next-cycle implication, disabled during reset
`define VZFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vzfe assertion failed");

`endif

FILE: design/vzfe_pkg.sv
// Package: widths, operation codes and control structs of the varint field encoder
package vzfe_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 64;
    localparam int INDEX_W  = 31;
    localparam int BYTE_W   = 8;
    localparam int GROUP_W  = 7;
    localparam int RCOUNT_W = 4;

    localparam logic [OP_W-1:0] OP_SKIP     = 3'd0;
    localparam logic [OP_W-1:0] OP_UNSIGNED = 3'd1;
    localparam logic [OP_W-1:0] OP_SIGNED   = 3'd2;
    localparam logic [OP_W-1:0] OP_FLOAT    = 3'd3;
    localparam logic [OP_W-1:0] OP_DOUBLE   = 3'd4;
    localparam logic [OP_W-1:0] OP_START    = 3'd5;

    localparam logic [INDEX_W-1:0]  INDEX_MAX   = 31'h7FFF_FFFF;
    localparam logic [RCOUNT_W-1:0] FLOAT_BYTES  = 4'd4;
    localparam logic [RCOUNT_W-1:0] DOUBLE_BYTES = 4'd8;
    localparam int                  SIGN_BIT     = 63;

    // Control from the sequencer to the byte serialiser
    typedef struct packed {
        logic                load;
        logic                step;
        logic                raw;
        logic [RCOUNT_W-1:0] raw_count;
    } ser_ctrl_t;

    // Status from the byte serialiser
    typedef struct packed {
        logic busy;
        logic last_group;
    } ser_stat_t;

endpackage

FILE: design/vzfe_in_if.sv
// Input channel interface: operation and raw field value
interface vzfe_in_if;
    logic                            valid;
    logic                            ready;
    logic [vzfe_pkg::OP_W-1:0]       operation;
    logic [vzfe_pkg::VALUE_W-1:0]    field_value;

    modport source (output valid, output operation, output field_value, input ready);
    modport sink   (input valid, input operation, input field_value, output ready);
endinterface

FILE: design/vzfe_out_if.sv
// Output channel interface: encoded byte stream with end-of-item mark
interface vzfe_out_if;
    logic                         valid;
    logic                         ready;
    logic [vzfe_pkg::BYTE_W-1:0]  out_byte;
    logic                         last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

FILE: design/vzfe_serialiser.sv
// Byte serialiser: shifts a loaded word out as varint groups or raw bytes
module vzfe_serialiser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  vzfe_pkg::ser_ctrl_t            ctrl,
    input  logic [vzfe_pkg::VALUE_W-1:0]   load_data,
    output logic [vzfe_pkg::BYTE_W-1:0]    cur_byte,
    output vzfe_pkg::ser_stat_t            stat
);

    logic [vzfe_pkg::VALUE_W-1:0]  sr_reg, sr_next;
    logic [vzfe_pkg::RCOUNT_W-1:0] cnt_reg, cnt_next;
    logic                          raw_reg, raw_next;
    logic                          busy_reg, busy_next;
    logic                          more_groups;
    logic                          last_group;

    // Current byte and end-of-word detection
    always_comb
    begin
        more_groups = |sr_reg[vzfe_pkg::VALUE_W-1:vzfe_pkg::GROUP_W];
        if (raw_reg)
        begin
            cur_byte   = sr_reg[vzfe_pkg::BYTE_W-1:0];
            last_group = (cnt_reg == vzfe_pkg::RCOUNT_W'(1));
        end
        else
        begin
            cur_byte   = {more_groups, sr_reg[vzfe_pkg::GROUP_W-1:0]};
            last_group = !more_groups;
        end
    end

    assign stat.busy       = busy_reg;
    assign stat.last_group = last_group;

    // Load or shift by one digit
    always_comb
    begin
        sr_next   = sr_reg;
        cnt_next  = cnt_reg;
        raw_next  = raw_reg;
        busy_next = busy_reg;
        priority if (ctrl.load)
        begin
            sr_next   = load_data;
            cnt_next  = ctrl.raw_count;
            raw_next  = ctrl.raw;
            busy_next = 1'b1;
        end
        else if (ctrl.step)
        begin
            if (raw_reg)
                sr_next = {{vzfe_pkg::BYTE_W{1'b0}},
                           sr_reg[vzfe_pkg::VALUE_W-1:vzfe_pkg::BYTE_W]};
            else
                sr_next = {{vzfe_pkg::GROUP_W{1'b0}},
                           sr_reg[vzfe_pkg::VALUE_W-1:vzfe_pkg::GROUP_W]};
            cnt_next  = cnt_reg - vzfe_pkg::RCOUNT_W'(1);
            busy_next = !last_group;
        end
        else
        begin
            // hold
            sr_next = sr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            raw_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            raw_reg  <= raw_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload shift register
    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
    end

endmodule

FILE: design/varint_zigzag_field_encoder_core.sv
// Top level: field sequencer, index counter and output register of the varint encoder
//
// Usage:
//   in_ch  takes one field per transaction: operation and a 64-bit field_value.
//   out_ch delivers the encoded stream one byte per transaction; last_byte
//          marks the final byte of the item that produced it.
// A field with a nonzero value (for float and double, ignoring the sign) emits its index as a
// varint tag (1 to 5 bytes), then the value: varint (zigzag for signed, 1 to 10 bytes) or 4/8 raw bytes.
// Flow of items:
//   An item that emits nothing (skip, start, zero value, undefined code) is
//   taken and leaves the block idle. An item that emits N bytes (2 to 15) occupies
//   the block while the serialiser's shift register produces one byte per cycle
//   unless the output stalls; the tag loads on acceptance, each byte then passes
//   the output register. in_ch.ready rises once the final byte is in the output
//   register, so the next item is taken while that byte still waits.
// Stall: when out_ch.ready is low and the output register is full, it holds
//   and the serialiser stops shifting; nothing is dropped.
// Reset: rst_n clears the field index to zero and empties the output register.
`include "varint_zigzag_field_encoder_core_defines.svh"

module varint_zigzag_field_encoder_core (
    input  logic             clk,
    input  logic             rst_n,
    vzfe_in_if.sink          in_ch,
    vzfe_out_if.source       out_ch
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAG,
        S_VALUE
    } state_t;

    state_t                              state_reg;
    logic [vzfe_pkg::INDEX_W-1:0]        index_reg;
    logic [vzfe_pkg::VALUE_W-1:0]        value_reg;
    logic                                val_raw_reg;
    logic [vzfe_pkg::RCOUNT_W-1:0]       val_cnt_reg;
    logic                                out_valid_reg;
    logic [vzfe_pkg::BYTE_W-1:0]         out_byte_reg;
    logic                                out_last_reg;

    logic                                accept;
    logic                                emit;
    logic                                counts;
    logic [vzfe_pkg::VALUE_W-1:0]        value_sel;
    logic                                raw_sel;
    logic [vzfe_pkg::RCOUNT_W-1:0]       cnt_sel;
    logic                                slot_free;
    logic                                step;
    logic [vzfe_pkg::INDEX_W-1:0]        index_inc;

    vzfe_pkg::ser_ctrl_t                 ser_ctrl;
    vzfe_pkg::ser_stat_t                 ser_stat;
    logic [vzfe_pkg::VALUE_W-1:0]        ser_data;
    logic [vzfe_pkg::BYTE_W-1:0]         ser_byte;

    assign in_ch.ready      = (state_reg == S_IDLE);
    assign accept           = in_ch.valid && in_ch.ready;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.last_byte = out_last_reg;

    // Decode operation: value to send, format and zero test
    always_comb
    begin
        emit      = 1'b0;
        counts    = 1'b1;
        raw_sel   = 1'b0;
        cnt_sel   = vzfe_pkg::DOUBLE_BYTES;
        value_sel = in_ch.field_value;
        unique case (in_ch.operation)
            vzfe_pkg::OP_SKIP:
            begin
                emit = 1'b0;
            end
            vzfe_pkg::OP_UNSIGNED:
            begin
                emit = (in_ch.field_value != '0);
            end
            vzfe_pkg::OP_SIGNED:
            begin
                emit      = (in_ch.field_value != '0);
                value_sel = {in_ch.field_value[vzfe_pkg::VALUE_W-2:0], 1'b0}
                          ^ {vzfe_pkg::VALUE_W{in_ch.field_value[vzfe_pkg::SIGN_BIT]}};
            end
            vzfe_pkg::OP_FLOAT:
            begin
                emit      = (in_ch.field_value[30:0] != '0);
                raw_sel   = 1'b1;
                cnt_sel   = vzfe_pkg::FLOAT_BYTES;
                value_sel = {32'b0, in_ch.field_value[31:0]};
            end
            vzfe_pkg::OP_DOUBLE:
            begin
                emit    = (in_ch.field_value[vzfe_pkg::VALUE_W-2:0] != '0);
                raw_sel = 1'b1;
            end
            default:
            begin
                // start of message and undefined codes
                counts = 1'b0;
            end
        endcase
    end

    // Saturating index increment
    assign index_inc = (index_reg == vzfe_pkg::INDEX_MAX) ? index_reg
                     : index_reg + vzfe_pkg::INDEX_W'(1);

    // Serialiser control: tag loads on acceptance, value loads after the tag
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign step      = (state_reg != S_IDLE) && ser_stat.busy && slot_free;

    always_comb
    begin
        ser_ctrl.step = step;
        if (state_reg == S_IDLE)
        begin
            ser_ctrl.load      = accept && emit;
            ser_ctrl.raw       = 1'b0;
            ser_ctrl.raw_count = val_cnt_reg;
            ser_data           = {{(vzfe_pkg::VALUE_W-vzfe_pkg::INDEX_W){1'b0}}, index_reg};
        end
        else
        begin
            ser_ctrl.load      = step && (state_reg == S_TAG) && ser_stat.last_group;
            ser_ctrl.raw       = val_raw_reg;
            ser_ctrl.raw_count = val_cnt_reg;
            ser_data           = value_reg;
        end
    end

    vzfe_serialiser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ser_ctrl),
        .load_data (ser_data),
        .cur_byte  (ser_byte),
        .stat      (ser_stat)
    );

    // Sequencer, field index and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            index_reg     <= '0;
            value_reg     <= '0;
            val_raw_reg   <= 1'b0;
            val_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= ser_byte;
                out_last_reg  <= (state_reg == S_VALUE) && ser_stat.last_group;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_ch.operation == vzfe_pkg::OP_START)
                            index_reg <= '0;
                        else if (counts)
                            index_reg <= index_inc;
                        value_reg   <= value_sel;
                        val_raw_reg <= raw_sel;
                        val_cnt_reg <= cnt_sel;
                        if (emit)
                            state_reg <= S_TAG;
                    end
                end
                S_TAG:
                begin
                    if (step && ser_stat.last_group)
                        state_reg <= S_VALUE;
                end
                S_VALUE:
                begin
                    if (step && ser_stat.last_group)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Checks on sequencing
    `VZFE_ASSERT_NOW(a_busy_when_active, clk, rst_n, state_reg != S_IDLE, ser_stat.busy)
    `VZFE_ASSERT_NEXT(a_start_clears_index, clk, rst_n, accept && in_ch.operation == vzfe_pkg::OP_START, index_reg == '0)
    `VZFE_ASSERT_NEXT(a_last_marks_end, clk, rst_n, step && state_reg == S_VALUE && ser_stat.last_group, out_valid_reg && out_last_reg && state_reg == S_IDLE)
    `VZFE_ASSERT_NEXT(a_index_monotonic, clk, rst_n, !(accept && in_ch.operation == vzfe_pkg::OP_START), index_reg >= $past(index_reg))

endmodule

FILE: verif/tb_varint_zigzag_field_encoder_core.sv
// Self-checking testbench for the varint/zigzag field encoder: directed table, then random fields
module tb_varint_zigzag_field_encoder_core;

    import vzfe_pkg::*;

    // Operation codes the block leaves undefined
    localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

    localparam int DIRECTED_ROWS = 25;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 40;

    // One encoded byte as it should leave the block
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } enc_byte_t;

    // Directed row: bytes are listed first-out leftmost, count of them in n_bytes
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [3:0]         n_bytes;
        logic [119:0]       bytes;
    } field_row_t;

    localparam field_row_t FIELD_TABLE [DIRECTED_ROWS] = '{
        '{OP_UNSIGNED, 64'd1,                   1'b1, 4'd2,  120'h0001},
        '{OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd11, 120'h01FFFFFFFFFFFFFFFFFF01},
        '{OP_SIGNED,   64'h8000_0000_0000_0000, 1'b1, 4'd11, 120'h02FFFFFFFFFFFFFFFFFF01},
        '{OP_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd2,  120'h0301},
        '{OP_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 4'd11, 120'h04FEFFFFFFFFFFFFFFFF01},
        '{OP_FLOAT,    64'hDEAD_BEEF_0000_0000, 1'b1, 4'd0,  120'h0},
        '{OP_FLOAT,    64'h0000_0000_8000_0000, 1'b1, 4'd0,  120'h0},
        '{OP_FLOAT,    64'hFFFF_FFFF_3F80_0000, 1'b1, 4'd5,  120'h070000803F},
        '{OP_DOUBLE,   64'h8000_0000_0000_0000, 1'b1, 4'd0,  120'h0},
        '{OP_DOUBLE,   64'h7FF8_0000_0000_0000, 1'b1, 4'd9,  120'h09000000000000F87F},
        '{OP_SKIP,     64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd0,  120'h0},
        '{OP_RSVD_A,   64'h0123_4567_89AB_CDEF, 1'b1, 4'd0,  120'h0},
        '{OP_RSVD_B,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd0,  120'h0},
        '{OP_UNSIGNED, 64'd0,                   1'b1, 4'd0,  120'h0},
        '{OP_SIGNED,   64'd0,                   1'b1, 4'd0,  120'h0},
        '{OP_UNSIGNED, 64'd127,                 1'b1, 4'd2,  120'h0D7F},
        '{OP_UNSIGNED, 64'd128,                 1'b1, 4'd3,  120'h0E8001},
        '{OP_DOUBLE,   64'h0000_0000_0000_0001, 1'b1, 4'd9,  120'h0F0100000000000000},
        '{OP_FLOAT,    64'h0000_0000_8000_0001, 1'b1, 4'd5,  120'h1001000080},
        '{OP_START,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd0,  120'h0},
        '{OP_SIGNED,   64'd1,                   1'b1, 4'd2,  120'h0002},
        '{OP_SIGNED,   64'hFFFF_FFFF_FFFF_FFC0, 1'b0, 4'd0,  120'h0},
        '{OP_DOUBLE,   64'h0123_4567_89AB_CDEF, 1'b0, 4'd0,  120'h0},
        '{OP_UNSIGNED, 64'h0000_0000_0000_4000, 1'b0, 4'd0,  120'h0},
        '{OP_START,    64'd0,                   1'b0, 4'd0,  120'h0}
    };

    logic clk;
    logic rst_n;

    vzfe_in_if  in_ch ();
    vzfe_out_if out_ch ();

    varint_zigzag_field_encoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predictor state and the bytes still owed by the block
    logic [INDEX_W-1:0] field_index;
    logic [INDEX_W-1:0] peak_index;
    enc_byte_t          owed_bytes [$];

    // Side information for the transaction currently driven
    logic               row_typed;
    logic [3:0]         row_count;
    logic [119:0]       row_bytes;

    int                 idle_pct;
    int                 stall_pct;
    int                 mismatch_count;
    int                 fields_taken;
    int                 bytes_checked;
    int                 cycle_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle counter and watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d bytes still owed", cycle_count,
                 owed_bytes.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("[%0d] mismatch, %s: expected %02h, got %02h", cycle_count, what, want, got);
        mismatch_count++;
    endtask

    // LEB128: seven bits per byte, low group first, continuation in bit 7
    function automatic void put_varint(ref enc_byte_t q[$], input logic [63:0] v);
        enc_byte_t b;
        b.last = 1'b0;
        while (v >= 64'h80)
        begin
            b.data = {1'b1, v[6:0]};
            q.push_back(b);
            v = v >> 7;
        end
        b.data = v[7:0];
        q.push_back(b);
    endfunction

    // Raw little-endian bytes
    function automatic void put_raw(ref enc_byte_t q[$], input logic [63:0] v, input int count);
        enc_byte_t b;
        b.last = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            b.data = v[7:0];
            q.push_back(b);
            v = v >> 8;
        end
    endfunction

    // Bytes one field transaction produces; updates the running field index
    function automatic void encode_field(input logic [OP_W-1:0] op, input logic [63:0] value,
                                         ref enc_byte_t q[$]);
        logic        bump;
        logic [63:0] tag;
        logic [63:0] zz;
        bump = 1'b1;
        tag  = {33'd0, field_index};
        zz   = {value[62:0], 1'b0} ^ {64{value[63]}};
        case (op)
            OP_SKIP: ;
            OP_START:
            begin
                field_index = '0;
                bump = 1'b0;
            end
            OP_UNSIGNED:
                if (value != 64'd0)
                begin
                    put_varint(q, tag);
                    put_varint(q, value);
                end
            OP_SIGNED:
                if (value != 64'd0)
                begin
                    put_varint(q, tag);
                    put_varint(q, zz);
                end
            OP_FLOAT:
                if (value[30:0] != 31'd0)
                begin
                    put_varint(q, tag);
                    put_raw(q, value, int'(FLOAT_BYTES));
                end
            OP_DOUBLE:
                if (value[62:0] != 63'd0)
                begin
                    put_varint(q, tag);
                    put_raw(q, value, int'(DOUBLE_BYTES));
                end
            default: bump = 1'b0;
        endcase
        if (bump && field_index != INDEX_MAX)
            field_index = field_index + 1'b1;
        if (q.size() > 0)
            q[q.size() - 1].last = 1'b1;
    endfunction

    // Output check first, then prediction for a field taken on the same edge
    always @(posedge clk)
    begin : byte_monitor
        enc_byte_t want;
        enc_byte_t fresh [$];
        int        n;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                bytes_checked++;
                if (owed_bytes.size() == 0)
                    report_mismatch("byte with none owed", 8'h00, out_ch.out_byte);
                else
                begin
                    want = owed_bytes.pop_front();
                    if (out_ch.out_byte !== want.data)
                        report_mismatch("out_byte", want.data, out_ch.out_byte);
                    if (out_ch.last_byte !== want.last)
                        report_mismatch("last_byte", {7'd0, want.last},
                                        {7'd0, out_ch.last_byte});
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                fresh.delete();
                encode_field(in_ch.operation, in_ch.field_value, fresh);
                if (field_index > peak_index)
                    peak_index = field_index;
                fields_taken++;
                if (row_typed)
                begin
                    n = int'(row_count);
                    for (int i = 0; i < n; i++)
                    begin
                        want.data = row_bytes[8 * (n - 1 - i) +: 8];
                        want.last = (i == n - 1);
                        owed_bytes.push_back(want);
                    end
                end
                else
                    foreach (fresh[i])
                        owed_bytes.push_back(fresh[i]);
            end
        end
    end

    // Receiver pacing: random stalls, as often as stall_pct sets
    initial
    begin
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < stall_pct)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Drive one transaction from a negedge; returns at the negedge after acceptance
    task automatic send_field(input logic [OP_W-1:0] op, input logic [63:0] value,
                              input logic typed, input logic [3:0] n, input logic [119:0] bytes);
        row_typed = typed;
        row_count = n;
        row_bytes = bytes;
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.field_value <= value;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    // Hold the sender off until the block has delivered everything owed or DRAIN_LIMIT is reached
    task automatic wait_until_drained();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (owed_bytes.size() != 0 && waited < DRAIN_LIMIT);
    endtask

    // New message, then a run of skipped fields to push the index into longer tags
    task automatic skip_run(input int count);
        send_field(OP_START, {$urandom, $urandom}, 1'b0, 4'd0, 120'h0);
        repeat (count) send_field(OP_SKIP, {$urandom, $urandom}, 1'b0, 4'd0, 120'h0);
    endtask

    function automatic logic [OP_W-1:0] random_op(input logic allow_start);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return allow_start ? OP_START : OP_UNSIGNED;
        else if (r < 15)
            return OP_SKIP;
        else if (r < 18)
            return (r[0]) ? OP_RSVD_A : OP_RSVD_B;
        else if (r < 40)
            return OP_UNSIGNED;
        else if (r < 62)
            return OP_SIGNED;
        else if (r < 80)
            return OP_FLOAT;
        return OP_DOUBLE;
    endfunction

    // Values of every length, both zeros, small negatives and NaN/infinity patterns
    function automatic logic [63:0] random_value(input logic [OP_W-1:0] op);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0: return 64'd0;
            1: return (op == OP_DOUBLE) ? {raw[63], 63'd0} : {raw[63:32], raw[31], 31'd0};
            2: return ~(raw >> $urandom_range(1, 63));
            3, 4, 5: return raw >> $urandom_range(0, 63);
            6: return {raw[63], 11'h7FF, raw[51:32], raw[31], 8'hFF, raw[22:0]};
            default: return raw;
        endcase
    endfunction

    // Random fields; undefined codes are sent but not counted
    task automatic random_fields(input int count, input logic allow_start, input int quiet_tail);
        logic [OP_W-1:0] op;
        int              done;
        done = 0;
        while (done < count)
        begin
            if (done >= count - quiet_tail)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            else if (done % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 8;
                    2: idle_pct = 20;
                    default: idle_pct = 35;
                endcase
                stall_pct = idle_pct;
            end
            sender_gap();
            op = random_op(allow_start);
            send_field(op, random_value(op), 1'b0, 4'd0, 120'h0);
            if (op != OP_RSVD_A && op != OP_RSVD_B)
                done++;
        end
    endtask

    // Main sequence
    initial
    begin
        enc_byte_t left;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_SKIP;
        in_ch.field_value = '0;
        row_typed         = 1'b0;
        row_count         = '0;
        row_bytes         = '0;
        field_index       = '0;
        peak_index        = '0;
        idle_pct          = 20;
        stall_pct         = 20;
        mismatch_count    = 0;
        fields_taken      = 0;
        bytes_checked     = 0;
        cycle_count       = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table
        foreach (FIELD_TABLE[i])
        begin
            sender_gap();
            send_field(FIELD_TABLE[i].op, FIELD_TABLE[i].value, FIELD_TABLE[i].typed,
                       FIELD_TABLE[i].n_bytes, FIELD_TABLE[i].bytes);
        end
        wait_until_drained();

        // Random fields in short messages, then with two-byte tags
        random_fields(150, 1'b1, 0);
        skip_run(130);
        random_fields(60, 1'b0, 0);
        random_fields(100, 1'b0, 60);

        // Drain, then watch for stray bytes
        wait_until_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        while (owed_bytes.size() != 0)
        begin
            left = owed_bytes.pop_front();
            report_mismatch("byte never delivered", left.data, 8'h00);
        end

        $display("Covered %0d field transactions and %0d encoded bytes in %0d cycles;",
                 fields_taken, bytes_checked, cycle_count);
        $display("all six operations, both undefined codes, zero values and tags up to index %0d.",
                 peak_index);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
